/* src/mtstk_pkg.sv */
package mtstk_pkg;

    // value width of a request and of the reported top and minimum
    localparam int DATA_W  = 32;
    // stored entry width: wide enough to hold the encoded minimum marker
    localparam int ENTRY_W = 34;

    // requested operation
    typedef enum logic {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } req_t;

    // result status
    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_POP_EMPTY = 2'd1,
        STATUS_PUSH_FULL = 2'd2
    } status_t;

endpackage

/* src/mtstk_ram.sv */
module mtstk_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // single write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, holds its value when not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/min_tracking_stack.sv */
// latency: the result of a request is valid in the cycle after it is accepted
// throughput: one request per cycle while m_ready is high; the top entry is in a
//   register, the one below prefetched via the registered stack ram read port
// reset: clears the entry count, the minimum and the result valid; stack ram
//   contents are not cleared, no clearing pass, requests taken right after reset
module min_tracking_stack #(
    parameter int STACK_DEPTH = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_req_type,
    input  logic signed [31:0]                   s_push_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [1:0]                           m_status,
    output logic signed [31:0]                   m_top_value,
    output logic signed [31:0]                   m_min_value,
    output logic                                 m_is_empty,
    output logic [$clog2(STACK_DEPTH+1)-1:0]     m_entry_count
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int DW     = mtstk_pkg::DATA_W;
    localparam int EW     = mtstk_pkg::ENTRY_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO_CNT  = CNT_W'(2);

    // stack state
    logic [CNT_W-1:0]         fill_reg, fill_next;
    logic signed [DW-1:0]     min_reg, min_next;
    logic signed [EW-1:0]     top_reg, top_next;

    // result register
    logic                     m_valid_reg;
    mtstk_pkg::status_t       status_reg, status_next;
    logic signed [DW-1:0]     top_out_reg, top_out_next;
    logic signed [DW-1:0]     min_out_reg, min_out_next;
    logic                     empty_reg, empty_next;
    logic [CNT_W-1:0]         count_reg;

    // ram side
    logic                     ram_wr_en;
    logic [ADDR_W-1:0]        ram_wr_addr;
    logic signed [EW-1:0]     ram_wr_data;
    logic                     ram_rd_en;
    logic [ADDR_W-1:0]        ram_rd_addr;
    logic [EW-1:0]            below_entry;

    logic                     accept;
    logic signed [EW-1:0]     value_ext;
    logic signed [EW-1:0]     min_ext;
    logic signed [EW-1:0]     restored;
    logic [CNT_W-1:0]         rd_index;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign value_ext = EW'(s_push_value);
    assign min_ext   = EW'(min_reg);
    assign restored  = (min_ext <<< 1) - top_reg;

    // request decode and state update
    always_comb begin
        fill_next   = fill_reg;
        min_next    = min_reg;
        top_next    = top_reg;
        status_next = mtstk_pkg::STATUS_DONE;
        ram_wr_en   = 1'b0;
        ram_wr_data = value_ext;
        if (s_req_type == mtstk_pkg::REQ_PUSH) begin
            if (fill_reg == FULL_CNT) begin
                status_next = mtstk_pkg::STATUS_PUSH_FULL;
            end else begin
                ram_wr_en = accept;
                if (fill_reg == '0) begin
                    min_next = s_push_value;
                end else if (s_push_value < min_reg) begin
                    // new minimum: store marker 2*v - min
                    ram_wr_data = (value_ext <<< 1) - min_ext;
                    min_next    = s_push_value;
                end
                top_next  = ram_wr_data;
                fill_next = fill_reg + ONE_CNT;
            end
        end else begin
            if (fill_reg == '0) begin
                status_next = mtstk_pkg::STATUS_POP_EMPTY;
            end else begin
                // marker on top: recover the previous minimum
                if (top_reg < min_ext) begin
                    min_next = restored[DW-1:0];
                end
                top_next  = below_entry;
                fill_next = fill_reg - ONE_CNT;
            end
        end
    end

    assign ram_wr_addr = fill_reg[ADDR_W-1:0];

    // prefetch the entry below the new top
    assign rd_index    = fill_next - TWO_CNT;
    assign ram_rd_addr = rd_index[ADDR_W-1:0];
    assign ram_rd_en   = accept && (fill_next >= TWO_CNT);

    // result values after the request
    always_comb begin
        top_out_next = '0;
        min_out_next = '0;
        empty_next   = (fill_next == '0);
        if (fill_next != '0) begin
            min_out_next = min_next;
            if (top_next < EW'(min_next)) begin
                top_out_next = min_next;
            end else begin
                top_out_next = top_next[DW-1:0];
            end
        end
    end

    mtstk_ram #(
        .WIDTH (EW),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (below_entry)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            min_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                fill_reg <= fill_next;
                min_reg  <= min_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // top entry and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            top_reg     <= top_next;
            status_reg  <= status_next;
            top_out_reg <= top_out_next;
            min_out_reg <= min_out_next;
            empty_reg   <= empty_next;
            count_reg   <= fill_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_top_value   = top_out_reg;
    assign m_min_value   = min_out_reg;
    assign m_is_empty    = empty_reg;
    assign m_entry_count = count_reg;

    // count never passes the depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FULL_CNT)
        else $error("entry count beyond stack depth");

    // a held top value is never below the minimum
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_is_empty) |-> (m_top_value >= m_min_value))
        else $error("top value below minimum");

    // a push on a full stack is rejected and leaves the count alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_req_type == mtstk_pkg::REQ_PUSH && fill_reg == FULL_CNT)
        |=> (m_status == mtstk_pkg::STATUS_PUSH_FULL && fill_reg == FULL_CNT))
        else $error("push on full not rejected");

    // an empty result carries zero top and minimum
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_empty) |-> (m_top_value == '0 && m_min_value == '0
                                     && m_entry_count == '0))
        else $error("empty result carries data");

endmodule

/* verif/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = 1024;
    localparam int COUNT_W        = $clog2(DEPTH + 1);
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int QUIET_TAIL     = 150;
    localparam int DRAIN_CYCLES   = 10;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        mtstk_pkg::req_t                     op;
        logic signed [mtstk_pkg::DATA_W-1:0] value;
    } stack_req_t;

    typedef struct {
        mtstk_pkg::status_t                  status;
        logic signed [mtstk_pkg::DATA_W-1:0] top;
        logic signed [mtstk_pkg::DATA_W-1:0] minimum;
        logic                                empty;
        logic [COUNT_W-1:0]                  count;
    } stack_resp_t;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic                                s_req_type = 1'b0;
    logic signed [mtstk_pkg::DATA_W-1:0] s_push_value = '0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic [1:0]                          m_status;
    logic signed [mtstk_pkg::DATA_W-1:0] m_top_value;
    logic signed [mtstk_pkg::DATA_W-1:0] m_min_value;
    logic                                m_is_empty;
    logic [COUNT_W-1:0]                  m_entry_count;

    min_tracking_stack #(
        .STACK_DEPTH (DEPTH)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_push_value  (s_push_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_top_value   (m_top_value),
        .m_min_value   (m_min_value),
        .m_is_empty    (m_is_empty),
        .m_entry_count (m_entry_count)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // requests waiting to be driven and results still owed by the block
    stack_req_t  pending_reqs[$];
    stack_resp_t owed_results[$];

    // shadow stack: entries, fill level and running minimum
    logic signed [mtstk_pkg::ENTRY_W-1:0] shadow_store [DEPTH];
    int unsigned                          shadow_fill = 0;
    logic signed [mtstk_pkg::DATA_W-1:0]  shadow_min = '0;

    // stimulus-side fill tracking and descending value trend
    int                                   gen_fill = 0;
    logic signed [mtstk_pkg::DATA_W-1:0]  trend_value = '0;

    logic req_fire = 1'b0;
    int   send_gap = 0;
    int   recv_gap = 0;
    int   idle_cycles = 0;
    int   mismatch_count = 0;

    // update the shadow stack for one request and work out its result
    function automatic stack_resp_t stack_update(stack_req_t r);
        stack_resp_t                          resp;
        logic signed [mtstk_pkg::ENTRY_W-1:0] stored;
        longint                               v;
        longint                               m;
        v = r.value;
        m = shadow_min;
        resp.status = mtstk_pkg::STATUS_DONE;
        if (r.op == mtstk_pkg::REQ_PUSH) begin
            if (shadow_fill >= DEPTH) begin
                resp.status = mtstk_pkg::STATUS_PUSH_FULL;
            end else if (shadow_fill == 0) begin
                shadow_min = r.value;
                shadow_store[0] = mtstk_pkg::ENTRY_W'(v);
                shadow_fill = 1;
            end else begin
                // a new minimum leaves an encoded marker behind
                if (v < m) begin
                    shadow_store[shadow_fill] = mtstk_pkg::ENTRY_W'(2 * v - m);
                    shadow_min = r.value;
                end else begin
                    shadow_store[shadow_fill] = mtstk_pkg::ENTRY_W'(v);
                end
                shadow_fill++;
            end
        end else begin
            if (shadow_fill == 0) begin
                resp.status = mtstk_pkg::STATUS_POP_EMPTY;
            end else begin
                // popping a marker brings back the previous minimum
                stored = shadow_store[shadow_fill - 1];
                if (longint'(stored) < m)
                    shadow_min = mtstk_pkg::DATA_W'(2 * m - longint'(stored));
                shadow_fill--;
            end
        end
        // decoded top and minimum, zero when empty
        if (shadow_fill != 0) begin
            stored = shadow_store[shadow_fill - 1];
            if (longint'(stored) < longint'(shadow_min))
                resp.top = shadow_min;
            else
                resp.top = mtstk_pkg::DATA_W'(stored);
            resp.minimum = shadow_min;
        end else begin
            resp.top = '0;
            resp.minimum = '0;
        end
        resp.empty = (shadow_fill == 0);
        resp.count = COUNT_W'(shadow_fill);
        return resp;
    endfunction

    task automatic queue_req(mtstk_pkg::req_t op, logic signed [mtstk_pkg::DATA_W-1:0] value);
        stack_req_t r;
        r.op = op;
        r.value = value;
        pending_reqs.push_back(r);
        if (op == mtstk_pkg::REQ_PUSH && gen_fill < DEPTH)
            gen_fill++;
        else if (op == mtstk_pkg::REQ_POP && gen_fill > 0)
            gen_fill--;
    endtask

    // mix of full-range, small, extreme and descending values
    function automatic logic signed [mtstk_pkg::DATA_W-1:0] pick_value();
        int k;
        logic signed [mtstk_pkg::DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5: begin
                k = $urandom_range(0, 32);
                v = k - 16;
            end
            6: begin
                case ($urandom_range(0, 3))
                    0: v = 32'sh7fffffff;
                    1: v = 32'sh80000000;
                    2: v = -1;
                    default: v = 0;
                endcase
            end
            9: begin
                trend_value = $urandom;
                v = trend_value;
            end
            default: begin
                trend_value = trend_value - $urandom_range(0, 5000);
                v = trend_value;
            end
        endcase
        return v;
    endfunction

    task automatic queue_random(int pop_pct);
        mtstk_pkg::req_t op;
        op = ($urandom_range(0, 99) < pop_pct) ? mtstk_pkg::REQ_POP : mtstk_pkg::REQ_PUSH;
        queue_req(op, pick_value());
    endtask

    task automatic random_phase(int n, int pop_pct);
        repeat (n) queue_random(pop_pct);
    endtask

    // request driver, changes inputs on the falling edge
    always @(negedge aclk) begin
        stack_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !req_fire) begin
            // hold the current request until it is taken
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            s_valid <= 1'b0;
        end else if (pending_reqs.size() > QUIET_TAIL && $urandom_range(0, 19) == 0) begin
            send_gap <= $urandom_range(0, 16);
            s_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
            nxt = pending_reqs.pop_front();
            s_valid <= 1'b1;
            s_req_type <= nxt.op;
            s_push_value <= nxt.value;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // result back-pressure in random bursts
    always @(negedge aclk) begin
        if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_ready <= 1'b0;
        end else if (pending_reqs.size() > QUIET_TAIL && $urandom_range(0, 19) == 0) begin
            recv_gap <= $urandom_range(0, 16);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor: predict on each taken request, check each taken result
    always @(posedge aclk) begin
        stack_req_t  taken;
        stack_resp_t want;
        if (!aresetn) begin
            req_fire <= 1'b0;
            idle_cycles <= 0;
        end else begin
            req_fire <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                taken.op = mtstk_pkg::req_t'(s_req_type);
                taken.value = s_push_value;
                owed_results.push_back(stack_update(taken));
            end
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: result with no request outstanding", $realtime);
                end else begin
                    want = owed_results.pop_front();
                    if (m_status !== want.status || m_top_value !== want.top ||
                        m_min_value !== want.minimum || m_is_empty !== want.empty ||
                        m_entry_count !== want.count) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $write("%0t: exp status %0d top %0d min %0d empty %0d count %0d,",
                                   $realtime, want.status, want.top, want.minimum,
                                   want.empty, want.count);
                            $display(" got status %0d top %0d min %0d empty %0d count %0d",
                                     m_status, m_top_value, m_min_value, m_is_empty,
                                     m_entry_count);
                        end
                    end
                end
            end
            // watchdog on cycles with no handshake at all
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        // directed: empty pop, plain and marker pushes, extremes, pop back to empty
        queue_req(mtstk_pkg::REQ_POP, 0);
        queue_req(mtstk_pkg::REQ_PUSH, 5);
        queue_req(mtstk_pkg::REQ_PUSH, 7);
        queue_req(mtstk_pkg::REQ_PUSH, 5);
        queue_req(mtstk_pkg::REQ_PUSH, 3);
        queue_req(mtstk_pkg::REQ_PUSH, 32'sh80000000);
        queue_req(mtstk_pkg::REQ_PUSH, 32'sh80000000);
        repeat (6) queue_req(mtstk_pkg::REQ_POP, 32'sh7fffffff);
        queue_req(mtstk_pkg::REQ_POP, -1);
        // stale minimum overwritten by push on empty, widest marker
        queue_req(mtstk_pkg::REQ_PUSH, 32'sh7fffffff);
        queue_req(mtstk_pkg::REQ_PUSH, 32'sh80000000);
        queue_req(mtstk_pkg::REQ_PUSH, -1);
        queue_req(mtstk_pkg::REQ_PUSH, 0);
        repeat (4) queue_req(mtstk_pkg::REQ_POP, 0);
        queue_req(mtstk_pkg::REQ_PUSH, -1);
        queue_req(mtstk_pkg::REQ_PUSH, 32'sh7fffffff);
        queue_req(mtstk_pkg::REQ_POP, 32'sh80000000);

        // random: churn near empty, fill to full, bang on full, then mixed
        random_phase(100, 50);
        while (gen_fill < DEPTH) queue_random(3);
        random_phase(30, 40);
        random_phase(120, 60);

        // hold reset, then release it on a falling edge
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() != 0 || s_valid || owed_results.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatch_count == 0 && owed_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/mtstk_pkg.sv
src/mtstk_ram.sv
src/min_tracking_stack.sv
verif/tb.sv
